/* sv/rfg_pkg.sv */
package rfg_pkg;

  // Largest usable screen dimension; larger register values are clamped to it.
  localparam int unsigned MaxDim = 4096;
  localparam int unsigned DimW   = $clog2(MaxDim) + 1;

  // Configuration register indexes and reset values.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgScreenWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgScreenHeight = 1'b1;
  localparam logic [DimW-1:0] ScreenWidthRst  = DimW'(640);
  localparam logic [DimW-1:0] ScreenHeightRst = DimW'(480);

  // Input field codes.
  localparam logic OpStart = 1'b0;
  localparam logic OpStep  = 1'b1;
  localparam logic [1:0] ModeVGrad = 2'd1;
  localparam logic [1:0] ModeHGrad = 2'd2;

  // Fixed field and datapath widths.
  localparam int unsigned CoordW = 16;
  localparam int unsigned ClipW  = CoordW + 2;
  localparam int unsigned AddrW  = 24;
  localparam int unsigned ColorW = 32;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned NumChan = 3;
  localparam int unsigned OffW   = CoordW - 1;
  localparam int unsigned ProdW  = ChanW + OffW;
  localparam int unsigned DsrW   = OffW + ChanW - 1;
  localparam int unsigned DivCntW = $clog2(ChanW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic start_load;
    logic mul_load;
    logic div_run;
    logic write;
  } ctrl_cmd_t;

  typedef struct packed {
    logic busy;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

/* sv/rfg_if.sv */
interface rfg_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [1:0]         mode;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic signed [15:0] rect_w;
  logic signed [15:0] rect_h;
  logic [31:0]        color_a;
  logic [31:0]        color_b;

  modport source (
    output valid, opcode, mode, rect_x, rect_y, rect_w, rect_h, color_a, color_b,
    input  ready
  );
  modport sink (
    input  valid, opcode, mode, rect_x, rect_y, rect_w, rect_h, color_a, color_b,
    output ready
  );
endinterface

interface rfg_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_address;
  logic [31:0] pixel_color;
  logic        last_pixel;

  modport source (
    output valid, pixel_address, pixel_color, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_address, pixel_color, last_pixel,
    output ready
  );
endinterface

/* sv/rfg_div.sv */
module rfg_div import rfg_pkg::*; (
  input  logic             clk_i,
  input  logic             init_i,
  input  logic             run_i,
  input  logic [ProdW-1:0] dividend_i,
  input  logic [OffW-1:0]  divisor_i,
  output logic [ChanW-1:0] quot_o
);

  logic [ProdW-1:0] rem_q, rem_d;
  logic [DsrW-1:0]  dsr_q, dsr_d;
  logic [ChanW-1:0] quot_q, quot_d;
  logic             fits;

  // Restoring division, one quotient bit per cycle while run_i is high, most significant first.
  // The quotient is known to fit in one color channel.
  assign fits = rem_q >= ProdW'(dsr_q);

  always_comb begin
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quot_d = quot_q;
    if (init_i) begin
      rem_d  = dividend_i;
      dsr_d  = {divisor_i, {(ChanW-1){1'b0}}};
      quot_d = '0;
    end else if (run_i) begin
      if (fits) begin
        rem_d = rem_q - ProdW'(dsr_q);
      end
      quot_d = {quot_q[ChanW-2:0], fits};
      dsr_d  = dsr_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    quot_q <= quot_d;
  end

  assign quot_o = quot_q;

endmodule

/* sv/rfg_ctrl.sv */
module rfg_ctrl import rfg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_opcode_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   step_go;

  assign step_go = (state_q == ST_IDLE) && in_valid_i && (in_opcode_i == OpStep)
                   && status_i.busy;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (step_go) state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_last) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.start_load = in_valid_i && (in_opcode_i == OpStart);
        cmd_o.mul_load   = step_go;
      end
      ST_MUL: begin
      end
      ST_DIV: begin
        cmd_o.div_run = 1'b1;
      end
      ST_WRITE: begin
        cmd_o.write = status_i.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/rfg_datapath.sv */
module rfg_datapath import rfg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [DimW-1:0]          cfg_wdata_i,
  input  logic [1:0]               mode_i,
  input  logic signed [CoordW-1:0] rect_x_i,
  input  logic signed [CoordW-1:0] rect_y_i,
  input  logic signed [CoordW-1:0] rect_w_i,
  input  logic signed [CoordW-1:0] rect_h_i,
  input  logic [ColorW-1:0]        color_a_i,
  input  logic [ColorW-1:0]        color_b_i,
  input  ctrl_cmd_t                cmd_i,
  output dp_status_t               status_o,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [AddrW-1:0]         pixel_address_o,
  output logic [ColorW-1:0]        pixel_color_o,
  output logic                     last_pixel_o
);

  // Configuration registers.
  logic [DimW-1:0] scr_w_q, scr_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= ScreenWidthRst;
      scr_h_q <= ScreenHeightRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgScreenWidth)  scr_w_q <= cfg_wdata_i;
      if (cfg_idx_i == CfgScreenHeight) scr_h_q <= cfg_wdata_i;
    end
  end

  // Effective screen size, clamped to the largest supported dimension.
  logic [DimW-1:0] sw, sh;
  assign sw = (scr_w_q > DimW'(MaxDim)) ? DimW'(MaxDim) : scr_w_q;
  assign sh = (scr_h_q > DimW'(MaxDim)) ? DimW'(MaxDim) : scr_h_q;

  // Clip the incoming rectangle against the screen.
  logic signed [ClipW-1:0] x_e, y_e, w_e, h_e, sw_e, sh_e;
  logic signed [ClipW-1:0] cx, cy, cw0, ch0, cw, ch, right_e, bot_e;
  logic                    busy_d;

  always_comb begin
    x_e  = ClipW'(rect_x_i);
    y_e  = ClipW'(rect_y_i);
    w_e  = ClipW'(rect_w_i);
    h_e  = ClipW'(rect_h_i);
    sw_e = $signed({{(ClipW-DimW){1'b0}}, sw});
    sh_e = $signed({{(ClipW-DimW){1'b0}}, sh});
    cx   = x_e[ClipW-1] ? '0 : x_e;
    cy   = y_e[ClipW-1] ? '0 : y_e;
    cw0  = x_e[ClipW-1] ? w_e + x_e : w_e;
    ch0  = y_e[ClipW-1] ? h_e + y_e : h_e;
    cw   = (cx + cw0 > sw_e) ? sw_e - cx : cw0;
    ch   = (cy + ch0 > sh_e) ? sh_e - cy : ch0;
    busy_d  = (cw > 0) && (ch > 0);
    right_e = cx + cw - ClipW'(1);
    bot_e   = cy + ch - ClipW'(1);
  end

  // Command state.
  logic                     busy_q;
  logic [DimW-1:0]          col_q, row_q, left_q, right_q, bot_q;
  logic signed [CoordW-1:0] org_x_q, org_y_q, span_q;
  logic [1:0]               mode_q;
  logic [ColorW-1:0]        col_a_q, col_b_q;
  logic                     last;

  assign last = (col_q == right_q) && (row_q == bot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (cmd_i.start_load) begin
      busy_q <= busy_d;
    end else if (cmd_i.write && last) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_load) begin
      mode_q  <= mode_i;
      col_a_q <= color_a_i;
      col_b_q <= color_b_i;
      org_x_q <= rect_x_i;
      org_y_q <= rect_y_i;
      span_q  <= (mode_i == ModeHGrad) ? rect_w_i : rect_h_i;
      if (busy_d) begin
        left_q  <= cx[DimW-1:0];
        right_q <= right_e[DimW-1:0];
        bot_q   <= bot_e[DimW-1:0];
        col_q   <= cx[DimW-1:0];
        row_q   <= cy[DimW-1:0];
      end
    end else if (cmd_i.write && !last) begin
      // Raster walk: left to right, then down one row.
      if (col_q >= right_q) begin
        col_q <= left_q;
        row_q <= row_q + DimW'(1);
      end else begin
        col_q <= col_q + DimW'(1);
      end
    end
  end

  // Gradient position: offset from the unclipped top or left edge.
  logic signed [ClipW-1:0] pos_e, org_e;
  logic [OffW-1:0]         t;
  logic                    grad;

  assign grad  = (mode_q == ModeVGrad) || (mode_q == ModeHGrad);
  assign pos_e = (mode_q == ModeVGrad) ? $signed({{(ClipW-DimW){1'b0}}, row_q})
                                       : $signed({{(ClipW-DimW){1'b0}}, col_q});
  assign org_e = (mode_q == ModeVGrad) ? ClipW'(org_y_q) : ClipW'(org_x_q);
  assign t     = OffW'(pos_e - org_e);

  // Per channel: |b - a| * t, divided by the span, added to or taken from a.
  logic [NumChan-1:0][ChanW-1:0] ch_a, ch_b, diff, quot, mixed;
  logic [NumChan-1:0][ProdW-1:0] prod;
  logic [NumChan-1:0]            neg_q;

  for (genvar c = 0; c < NumChan; c++) begin : g_chan
    assign ch_a[c] = col_a_q[c*ChanW +: ChanW];
    assign ch_b[c] = col_b_q[c*ChanW +: ChanW];
    assign diff[c] = (ch_b[c] < ch_a[c]) ? ch_a[c] - ch_b[c] : ch_b[c] - ch_a[c];
    assign prod[c] = {{(ProdW-ChanW){1'b0}}, diff[c]} * {{(ProdW-OffW){1'b0}}, t};
    assign mixed[c] = neg_q[c] ? ch_a[c] - quot[c] : ch_a[c] + quot[c];

    always_ff @(posedge clk_i) begin
      if (cmd_i.mul_load) neg_q[c] <= ch_b[c] < ch_a[c];
    end

    rfg_div u_div (
      .clk_i      (clk_i),
      .init_i     (cmd_i.mul_load),
      .run_i      (cmd_i.div_run),
      .dividend_i (prod[c]),
      .divisor_i  (span_q[OffW-1:0]),
      .quot_o     (quot[c])
    );
  end

  // Division step counter.
  logic [DivCntW-1:0] div_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.mul_load) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_run) begin
      div_cnt_q <= div_cnt_q + DivCntW'(1);
    end
  end

  // Pixel address, registered once the step starts.
  logic [2*DimW-1:0] addr_full;
  logic [AddrW-1:0]  addr_q;

  assign addr_full = {{DimW{1'b0}}, row_q} * {{DimW{1'b0}}, sw}
                     + {{DimW{1'b0}}, col_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) addr_q <= addr_full[AddrW-1:0];
  end

  // Output register; holds the result until the sink takes the transfer.
  logic                out_valid_q;
  logic [AddrW-1:0]    out_addr_q;
  logic [ColorW-1:0]   out_color_q;
  logic                out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.write) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      out_addr_q  <= addr_q;
      out_color_q <= grad ? {{(ColorW-NumChan*ChanW){1'b0}}, mixed} : col_a_q;
      out_last_q  <= last;
    end
  end

  assign status_o.busy     = busy_q;
  assign status_o.div_last = div_cnt_q == DivCntW'(ChanW - 1);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign pixel_address_o = out_addr_q;
  assign pixel_color_o   = out_color_q;
  assign last_pixel_o    = out_last_q;

endmodule

/* sv/rect_fill_gradient_engine_top.sv */
// Clipped rectangle fill with an optional vertical or horizontal linear
// gradient. A start transfer (opcode 0) clips the rectangle to the screen
// and produces no output; if nothing is left the engine stays idle. Each
// step transfer (opcode 1) then yields one back-buffer write in row-major
// order, with the last write flagged. A step that arrives while no command
// is active is consumed without output. A step first registers the address
// and the per-channel products, passes a wait state, then runs the
// bit-serial divide by the gradient span (one quotient bit per cycle, three
// channels in parallel), and finally loads the output register once it is
// free. The input is not taken during that time; a finished result waits in
// the output register without holding up the next input transfer. Screen
// size registers are clamped to 4096 and should be written only while the
// engine is idle.
module rect_fill_gradient_engine_top import rfg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DimW-1:0]    cfg_wdata_i,
  rfg_in_if.sink             in_i,
  rfg_out_if.source          out_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  rfg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .in_ready_o  (in_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rfg_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .mode_i          (in_i.mode),
    .rect_x_i        (in_i.rect_x),
    .rect_y_i        (in_i.rect_y),
    .rect_w_i        (in_i.rect_w),
    .rect_h_i        (in_i.rect_h),
    .color_a_i       (in_i.color_a),
    .color_b_i       (in_i.color_b),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .pixel_address_o (out_o.pixel_address),
    .pixel_color_o   (out_o.pixel_color),
    .last_pixel_o    (out_o.last_pixel)
  );

endmodule
